// ----- sv/bcpc_pkg.sv -----
// shared types and constants for the contact phase classifier
`timescale 1ns / 1ps

package bcpc_pkg;

  localparam int FORCE_W = 16;
  localparam int PROB_W  = 24;
  localparam int LIK_W   = 40;
  localparam int HYP_N   = 3;

  // register map, word index on paddr[4:2]
  localparam logic [2:0] REG_MEAN_TWO    = 3'd0;
  localparam logic [2:0] REG_MEAN_FOUR   = 3'd1;
  localparam logic [2:0] REG_MEAN_SWING  = 3'd2;
  localparam logic [2:0] REG_SPREAD_TWO  = 3'd3;
  localparam logic [2:0] REG_SPREAD_FOUR = 3'd4;
  localparam logic [2:0] REG_SPREAD_SWING = 3'd5;

  // hypothesis order: two-leg stance, four-leg stance, swing
  localparam logic [15:0] MEAN_RESET   [HYP_N] = '{16'd22400, 16'd10880, 16'd960};
  localparam logic [15:0] SPREAD_RESET [HYP_N] = '{16'd3200, 16'd3200, 16'd3200};
  localparam logic [23:0] BELIEF_RESET [HYP_N] = '{24'd10066330, 24'd3355443, 24'd3355443};

  localparam logic [23:0] PROB_LOW   = 24'd17;
  localparam logic [23:0] PROB_HIGH  = 24'd16777199;
  localparam logic [62:0] KEEP_LIMIT = 63'd2305843;
  localparam logic [31:0] INV_SQRT_2PI_Q32 = 32'd1713444047;
  localparam logic [63:0] ONE_Q62    = 64'h4000_0000_0000_0000;
  localparam logic [39:0] LIK_MAX    = 40'hFF_FFFF_FFFF;

  localparam logic [4:0] TERM_LAST   = 5'd20;
  localparam logic [2:0] SQUARE_LAST = 3'd5;

  localparam logic [5:0] EXP_DIV_STEPS   = 6'd37;
  localparam logic [5:0] LIK_DIV_STEPS   = 6'd48;
  localparam logic [5:0] RATIO_DIV_STEPS = 6'd26;
  localparam logic [5:0] KDIV_CYCLES     = 6'd8;

endpackage

// ----- sv/bayes_contact_phase_classifier.sv -----
// top level: recursive bayes contact phase classifier with shared multiply and divide units
//
// input channel: in_valid/in_stall carry a leg number and a contact force (Q10.6 N).
// output channel: out_valid/out_stall carry the updated three beliefs (Q0.24) of that
// leg, a stance flag and a flag for a normaliser too small to update the beliefs.
// an item whose leg number is not below LEG_COUNT is taken and dropped without a beat.
// apb port: six 16-bit registers (means and spreads) at byte addresses 0..20; pready
// is tied high, writes are meant to happen while no item is in flight.
// one item is worked on at a time and in_stall is high meanwhile. a force near a
// mean runs the 20-term exponential series through one 32x32 multiplier (four
// partial products per 64-bit product) and a divide-by-k step of 8 bits a cycle;
// a hypothesis whose force lies far from its mean skips the series. the block
// takes the next item in S_IDLE only after the result is loaded, so it takes no
// new item before it is through with the last one.
// the result sits in an output register: the next item is taken while it waits, and
// a finished item holds in its last step until the output register is free.
// reset (synchronous, rst_n low) restores the register defaults and sets every leg
// to 0.6 / 0.2 / 0.2.
`timescale 1ns / 1ps

module bayes_contact_phase_classifier
  import bcpc_pkg::*;
#(
  parameter int LEG_COUNT = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_leg_number,
  input  logic [15:0] in_contact_force,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_leg_out,
  output logic        out_stance_flag,
  output logic [23:0] out_prob_two_leg_stance,
  output logic [23:0] out_prob_four_leg_stance,
  output logic [23:0] out_prob_swing,
  output logic        out_kept_prior,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int LEG_W = (LEG_COUNT > 1) ? $clog2(LEG_COUNT) : 1;

  typedef enum logic [4:0] {
    S_IDLE, S_SETUP, S_SQD, S_SQS, S_EXP0, S_TMUL, S_TDIV, S_TACC,
    S_SQR, S_SQR2, S_PMUL, S_LDIV, S_LSAT, S_PROD, S_PSTO, S_SUM,
    S_RATIO, S_RSTO, S_DONE, S_MUL, S_DIV, S_KDIV
  } state_t;

  state_t state_r, state_nxt, ret_r, ret_nxt;

  logic [1:0]   leg_r, leg_nxt;
  logic [15:0]  force_r, force_nxt;
  logic [1:0]   h_r, h_nxt;
  logic [15:0]  s_r, s_nxt;
  logic [31:0]  d2_r, d2_nxt;
  logic [60:0]  x_r, x_nxt;
  logic [63:0]  term_r, term_nxt;
  logic [63:0]  sum_r, sum_nxt;
  logic [4:0]   k_r, k_nxt;
  logic [2:0]   sq_r, sq_nxt;
  logic [39:0]  lik_r, lik_nxt;
  logic [60:0]  n_r [HYP_N];
  logic [60:0]  n_nxt [HYP_N];
  logic [62:0]  tot_r, tot_nxt;
  logic [23:0]  post_r [HYP_N];
  logic [23:0]  post_nxt [HYP_N];
  logic         kept_r, kept_nxt;

  logic [63:0]  mul_a_r, mul_a_nxt, mul_b_r, mul_b_nxt;
  logic [127:0] acc_r, acc_nxt;
  logic [1:0]   ms_r, ms_nxt;

  logic [62:0]  div_rem_r, div_rem_nxt;
  logic [62:0]  div_den_r, div_den_nxt;
  logic [63:0]  div_feed_r, div_feed_nxt;
  logic [63:0]  div_q_r, div_q_nxt;
  logic [5:0]   div_cnt_r, div_cnt_nxt;

  logic         out_valid_r, out_valid_nxt;
  logic [1:0]   out_leg_r, out_leg_nxt;
  logic         out_stance_r, out_stance_nxt;
  logic [23:0]  out_p2_r, out_p2_nxt, out_p4_r, out_p4_nxt, out_ps_r, out_ps_nxt;
  logic         out_kept_r, out_kept_nxt;

  logic [15:0]  mean_r [HYP_N];
  logic [15:0]  mean_nxt [HYP_N];
  logic [15:0]  spread_r [HYP_N];
  logic [15:0]  spread_nxt [HYP_N];
  logic [23:0]  belief_r [LEG_COUNT][HYP_N];
  logic [23:0]  belief_nxt [LEG_COUNT][HYP_N];

  // datapath terms
  logic [LEG_W-1:0] leg_idx;
  logic [15:0]  mean_sel, spread_eff, diff;
  logic [23:0]  belief_sel;
  logic [31:0]  a_half, b_half;
  logic [63:0]  pp;
  logic [127:0] pp_sh;
  logic [63:0]  rem_sh, rem_sub;
  logic         div_ge;
  logic [63:0]  lik_t;
  logic [62:0]  tot_sum;
  logic [25:0]  ratio_inc;
  logic [24:0]  ratio_pr;
  logic [23:0]  ratio_cl;
  logic         cfg_wr;

  assign leg_idx    = LEG_W'(leg_r);
  assign mean_sel   = mean_r[h_r];
  assign spread_eff = (spread_r[h_r] == 16'd0) ? 16'd1 : spread_r[h_r];
  assign diff       = (force_r >= mean_sel) ? (force_r - mean_sel) : (mean_sel - force_r);
  assign belief_sel = belief_r[leg_idx][h_r];

  // shared 32x32 multiplier, one partial product a cycle
  assign a_half = ms_r[1] ? mul_a_r[63:32] : mul_a_r[31:0];
  assign b_half = ms_r[0] ? mul_b_r[63:32] : mul_b_r[31:0];
  assign pp     = a_half * b_half;

  always_comb begin
    case (ms_r)
      2'd0:    pp_sh = {64'd0, pp};
      2'd3:    pp_sh = {pp, 64'd0};
      default: pp_sh = {32'd0, pp, 32'd0};
    endcase
  end

  // shared restoring divider, one quotient bit a cycle
  assign rem_sh  = {div_rem_r, div_feed_r[63]};
  assign div_ge  = rem_sh >= {1'b0, div_den_r};
  assign rem_sub = rem_sh - {1'b0, div_den_r};

  assign lik_t     = acc_r[95:32] + {33'd0, s_r, 15'd0};
  assign tot_sum   = {2'b00, n_r[0]} + {2'b00, n_r[1]} + {2'b00, n_r[2]};
  assign ratio_inc = div_q_r[25:0] + 26'd1;
  assign ratio_pr  = ratio_inc[25:1];
  assign ratio_cl  = (ratio_pr < {1'b0, PROB_LOW})  ? PROB_LOW :
                     (ratio_pr > {1'b0, PROB_HIGH}) ? PROB_HIGH : ratio_pr[23:0];

  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    logic [5:0] kr;
    logic [7:0] kq;
    state_nxt = state_r;
    ret_nxt = ret_r;
    leg_nxt = leg_r;
    force_nxt = force_r;
    h_nxt = h_r;
    s_nxt = s_r;
    d2_nxt = d2_r;
    x_nxt = x_r;
    term_nxt = term_r;
    sum_nxt = sum_r;
    k_nxt = k_r;
    sq_nxt = sq_r;
    lik_nxt = lik_r;
    n_nxt = n_r;
    tot_nxt = tot_r;
    post_nxt = post_r;
    kept_nxt = kept_r;
    mul_a_nxt = mul_a_r;
    mul_b_nxt = mul_b_r;
    acc_nxt = acc_r;
    ms_nxt = ms_r;
    div_rem_nxt = div_rem_r;
    div_den_nxt = div_den_r;
    div_feed_nxt = div_feed_r;
    div_q_nxt = div_q_r;
    div_cnt_nxt = div_cnt_r;
    out_valid_nxt = out_valid_r;
    out_leg_nxt = out_leg_r;
    out_stance_nxt = out_stance_r;
    out_p2_nxt = out_p2_r;
    out_p4_nxt = out_p4_r;
    out_ps_nxt = out_ps_r;
    out_kept_nxt = out_kept_r;
    mean_nxt = mean_r;
    spread_nxt = spread_r;
    belief_nxt = belief_r;

    // divide-by-k, 8 quotient bits a cycle on a 5-bit remainder
    kr = {1'b0, div_rem_r[4:0]};
    kq = '0;
    for (int i = 0; i < 8; i++) begin
      kr = {kr[4:0], div_feed_r[63-i]};
      if (kr >= {1'b0, k_r}) begin
        kr = kr - {1'b0, k_r};
        kq[7-i] = 1'b1;
      end
    end

    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    if (cfg_wr) begin
      unique case (paddr[4:2])
        REG_MEAN_TWO:     mean_nxt[0] = pwdata[15:0];
        REG_MEAN_FOUR:    mean_nxt[1] = pwdata[15:0];
        REG_MEAN_SWING:   mean_nxt[2] = pwdata[15:0];
        REG_SPREAD_TWO:   spread_nxt[0] = pwdata[15:0];
        REG_SPREAD_FOUR:  spread_nxt[1] = pwdata[15:0];
        REG_SPREAD_SWING: spread_nxt[2] = pwdata[15:0];
        default: ;
      endcase
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          leg_nxt = in_leg_number;
          force_nxt = in_contact_force;
          if (32'(in_leg_number) < LEG_COUNT) begin
            h_nxt = 2'd0;
            state_nxt = S_SETUP;
          end
        end
      end
      S_SETUP: begin
        s_nxt = spread_eff;
        mul_a_nxt = 64'(diff);
        mul_b_nxt = 64'(diff);
        acc_nxt = '0;
        ms_nxt = '0;
        ret_nxt = S_SQD;
        state_nxt = S_MUL;
      end
      S_SQD: begin
        d2_nxt = acc_r[31:0];
        mul_a_nxt = 64'(s_r);
        mul_b_nxt = 64'(s_r);
        acc_nxt = '0;
        ms_nxt = '0;
        ret_nxt = S_SQS;
        state_nxt = S_MUL;
      end
      S_SQS: begin
        // exponent of 32 or more: likelihood is the floor value
        if ({6'd0, d2_r} >= {acc_r[31:0], 6'd0}) begin
          lik_nxt = 40'd1;
          state_nxt = S_PROD;
        end else begin
          // d2 * 2^31 / s2, upper quotient bits known zero
          div_rem_nxt = 63'(d2_r[31:6]);
          div_feed_nxt = {d2_r[5:0], 58'd0};
          div_den_nxt = 63'(acc_r[31:0]);
          div_q_nxt = '0;
          div_cnt_nxt = EXP_DIV_STEPS;
          ret_nxt = S_EXP0;
          state_nxt = S_DIV;
        end
      end
      S_EXP0: begin
        x_nxt = {div_q_r[36:0], 24'd0};
        term_nxt = ONE_Q62;
        sum_nxt = ONE_Q62;
        k_nxt = 5'd1;
        state_nxt = S_TMUL;
      end
      S_TMUL: begin
        mul_a_nxt = term_r;
        mul_b_nxt = 64'(x_r);
        acc_nxt = '0;
        ms_nxt = '0;
        ret_nxt = S_TDIV;
        state_nxt = S_MUL;
      end
      S_TDIV: begin
        div_feed_nxt = acc_r[125:62];
        div_rem_nxt = '0;
        div_q_nxt = '0;
        div_cnt_nxt = KDIV_CYCLES;
        ret_nxt = S_TACC;
        state_nxt = S_KDIV;
      end
      S_TACC: begin
        term_nxt = div_q_r;
        sum_nxt = k_r[0] ? (sum_r - div_q_r) : (sum_r + div_q_r);
        if (k_r == TERM_LAST) begin
          sq_nxt = '0;
          state_nxt = S_SQR;
        end else begin
          k_nxt = k_r + 5'd1;
          state_nxt = S_TMUL;
        end
      end
      S_SQR: begin
        mul_a_nxt = sum_r;
        mul_b_nxt = sum_r;
        acc_nxt = '0;
        ms_nxt = '0;
        ret_nxt = S_SQR2;
        state_nxt = S_MUL;
      end
      S_SQR2: begin
        sum_nxt = acc_r[125:62];
        if (sq_r == SQUARE_LAST) begin
          state_nxt = S_PMUL;
        end else begin
          sq_nxt = sq_r + 3'd1;
          state_nxt = S_SQR;
        end
      end
      S_PMUL: begin
        mul_a_nxt = sum_r;
        mul_b_nxt = 64'(INV_SQRT_2PI_Q32);
        acc_nxt = '0;
        ms_nxt = '0;
        ret_nxt = S_LDIV;
        state_nxt = S_MUL;
      end
      S_LDIV: begin
        // round-half-up of p / (s * 2^16) as floor((p + s*2^15) / 2^16) / s
        div_feed_nxt = {lik_t[63:16], 16'd0};
        div_rem_nxt = '0;
        div_den_nxt = 63'(s_r);
        div_q_nxt = '0;
        div_cnt_nxt = LIK_DIV_STEPS;
        ret_nxt = S_LSAT;
        state_nxt = S_DIV;
      end
      S_LSAT: begin
        if (div_q_r > 64'(LIK_MAX)) lik_nxt = LIK_MAX;
        else if (div_q_r == 64'd0) lik_nxt = 40'd1;
        else lik_nxt = div_q_r[39:0];
        state_nxt = S_PROD;
      end
      S_PROD: begin
        mul_a_nxt = 64'(lik_r);
        mul_b_nxt = 64'(belief_sel);
        acc_nxt = '0;
        ms_nxt = '0;
        ret_nxt = S_PSTO;
        state_nxt = S_MUL;
      end
      S_PSTO: begin
        n_nxt[h_r] = acc_r[63:3];
        if (h_r == 2'd2) begin
          state_nxt = S_SUM;
        end else begin
          h_nxt = h_r + 2'd1;
          state_nxt = S_SETUP;
        end
      end
      S_SUM: begin
        tot_nxt = tot_sum;
        h_nxt = 2'd0;
        if (tot_sum <= KEEP_LIMIT) begin
          post_nxt = belief_r[leg_idx];
          kept_nxt = 1'b1;
          state_nxt = S_DONE;
        end else begin
          kept_nxt = 1'b0;
          state_nxt = S_RATIO;
        end
      end
      S_RATIO: begin
        // first step gives the integer bit, then 25 fraction bits
        div_rem_nxt = 63'(n_r[h_r][60:1]);
        div_feed_nxt = {n_r[h_r][0], 63'd0};
        div_den_nxt = tot_r;
        div_q_nxt = '0;
        div_cnt_nxt = RATIO_DIV_STEPS;
        ret_nxt = S_RSTO;
        state_nxt = S_DIV;
      end
      S_RSTO: begin
        post_nxt[h_r] = ratio_cl;
        if (h_r == 2'd2) begin
          belief_nxt[leg_idx][0] = post_r[0];
          belief_nxt[leg_idx][1] = post_r[1];
          belief_nxt[leg_idx][2] = ratio_cl;
          state_nxt = S_DONE;
        end else begin
          h_nxt = h_r + 2'd1;
          state_nxt = S_RATIO;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_leg_nxt = leg_r;
          out_stance_nxt = (post_r[0] > post_r[2]) || (post_r[1] > post_r[2]);
          out_p2_nxt = post_r[0];
          out_p4_nxt = post_r[1];
          out_ps_nxt = post_r[2];
          out_kept_nxt = kept_r;
          h_nxt = 2'd0;
          state_nxt = S_IDLE;
        end
      end
      S_MUL: begin
        acc_nxt = acc_r + pp_sh;
        ms_nxt = ms_r + 2'd1;
        if (ms_r == 2'd3) state_nxt = ret_r;
      end
      S_DIV: begin
        div_rem_nxt = div_ge ? rem_sub[62:0] : rem_sh[62:0];
        div_q_nxt = {div_q_r[62:0], div_ge};
        div_feed_nxt = {div_feed_r[62:0], 1'b0};
        div_cnt_nxt = div_cnt_r - 6'd1;
        if (div_cnt_r == 6'd1) state_nxt = ret_r;
      end
      S_KDIV: begin
        div_rem_nxt = 63'(kr[4:0]);
        div_q_nxt = {div_q_r[55:0], kq};
        div_feed_nxt = {div_feed_r[55:0], 8'd0};
        div_cnt_nxt = div_cnt_r - 6'd1;
        if (div_cnt_r == 6'd1) state_nxt = ret_r;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ret_r <= S_IDLE;
      h_r <= 2'd0;
      out_valid_r <= 1'b0;
      mean_r <= MEAN_RESET;
      spread_r <= SPREAD_RESET;
      for (int i = 0; i < LEG_COUNT; i++) begin
        belief_r[i] <= BELIEF_RESET;
      end
    end else begin
      state_r <= state_nxt;
      ret_r <= ret_nxt;
      h_r <= h_nxt;
      out_valid_r <= out_valid_nxt;
      mean_r <= mean_nxt;
      spread_r <= spread_nxt;
      belief_r <= belief_nxt;
      leg_r <= leg_nxt;
      force_r <= force_nxt;
      s_r <= s_nxt;
      d2_r <= d2_nxt;
      x_r <= x_nxt;
      term_r <= term_nxt;
      sum_r <= sum_nxt;
      k_r <= k_nxt;
      sq_r <= sq_nxt;
      lik_r <= lik_nxt;
      n_r <= n_nxt;
      tot_r <= tot_nxt;
      post_r <= post_nxt;
      kept_r <= kept_nxt;
      mul_a_r <= mul_a_nxt;
      mul_b_r <= mul_b_nxt;
      acc_r <= acc_nxt;
      ms_r <= ms_nxt;
      div_rem_r <= div_rem_nxt;
      div_den_r <= div_den_nxt;
      div_feed_r <= div_feed_nxt;
      div_q_r <= div_q_nxt;
      div_cnt_r <= div_cnt_nxt;
      out_leg_r <= out_leg_nxt;
      out_stance_r <= out_stance_nxt;
      out_p2_r <= out_p2_nxt;
      out_p4_r <= out_p4_nxt;
      out_ps_r <= out_ps_nxt;
      out_kept_r <= out_kept_nxt;
    end
  end

  always_comb begin
    unique case (paddr[4:2])
      REG_MEAN_TWO:     prdata = {16'd0, mean_r[0]};
      REG_MEAN_FOUR:    prdata = {16'd0, mean_r[1]};
      REG_MEAN_SWING:   prdata = {16'd0, mean_r[2]};
      REG_SPREAD_TWO:   prdata = {16'd0, spread_r[0]};
      REG_SPREAD_FOUR:  prdata = {16'd0, spread_r[1]};
      REG_SPREAD_SWING: prdata = {16'd0, spread_r[2]};
      default:          prdata = 32'd0;
    endcase
  end

  assign pready = 1'b1;
  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_leg_out = out_leg_r;
  assign out_stance_flag = out_stance_r;
  assign out_prob_two_leg_stance = out_p2_r;
  assign out_prob_four_leg_stance = out_p4_r;
  assign out_prob_swing = out_ps_r;
  assign out_kept_prior = out_kept_r;

  // an updated beat always carries clamped probabilities
  a_prob_range: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kept_r) |->
      (out_p2_r >= PROB_LOW && out_p2_r <= PROB_HIGH &&
       out_p4_r >= PROB_LOW && out_p4_r <= PROB_HIGH &&
       out_ps_r >= PROB_LOW && out_ps_r <= PROB_HIGH))
    else $error("posterior outside clamp range");

  a_div_count: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DIV || state_r == S_KDIV) |-> (div_cnt_r != 6'd0))
    else $error("divider entered with zero step count");

  a_hyp_range: assert property (@(posedge clk) disable iff (!rst_n)
    h_r != 2'd3)
    else $error("hypothesis index out of range");

  // likelihood is floored before it weights the belief
  a_lik_floor: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROD) |-> (lik_r != 40'd0))
    else $error("likelihood below floor");

endmodule

// ----- bench/tb.sv -----
// self-checking testbench for the contact phase classifier
`timescale 1ns / 1ps

module tb;
  import bcpc_pkg::*;

  typedef struct packed {
    logic [1:0]  leg;
    logic        stance;
    logic [23:0] p_two;
    logic [23:0] p_four;
    logic [23:0] p_swing;
    logic        kept;
  } phase_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_leg_number = '0;
  logic [15:0] in_contact_force = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_leg_out;
  logic        out_stance_flag;
  logic [23:0] out_prob_two_leg_stance;
  logic [23:0] out_prob_four_leg_stance;
  logic [23:0] out_prob_swing;
  logic        out_kept_prior;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [4:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  // model copy of registers and per-leg beliefs, hypothesis order two, four, swing
  logic [15:0] model_mean [HYP_N];
  logic [15:0] model_spread [HYP_N];
  logic [23:0] model_belief [HYP_N][4];
  phase_result_t pending_results [$];
  int          error_count = 0;
  bit          quiet = 1'b0;
  int          out_gap = 0;

  bayes_contact_phase_classifier uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #200_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic logic [63:0] mul_shift(logic [63:0] a, logic [63:0] b, int sh);
    logic [127:0] p;
    p = {64'd0, a} * {64'd0, b};
    return 64'(p >> sh);
  endfunction

  function automatic logic [63:0] gauss_q40(logic [15:0] force_v, logic [15:0] mean_v,
                                            logic [15:0] spread_v);
    logic [63:0] s, d, d2, s2, e_q32, x, term, sum, p, dv, l;
    s = (spread_v == 0) ? 64'd1 : 64'(spread_v);
    d = (force_v > mean_v) ? 64'(force_v - mean_v) : 64'(mean_v - force_v);
    d2 = d * d;
    s2 = s * s;
    sum = 64'd0;
    if (d2 < 64 * s2) begin
      e_q32 = ((d2 / s2) << 31) + (((d2 % s2) << 31) / s2);
      x = e_q32 << 24;
      term = ONE_Q62;
      sum = ONE_Q62;
      for (int k = 1; k <= 20; k++) begin
        term = mul_shift(term, x, 62) / 64'(k);
        if (k % 2 == 1) sum = sum - term;
        else sum = sum + term;
      end
      for (int k = 0; k < 6; k++) sum = mul_shift(sum, sum, 62);
    end
    p = mul_shift(sum, 64'(INV_SQRT_2PI_Q32), 32);
    dv = s << 16;
    l = (p + (dv >> 1)) / dv;
    if (l > 64'(LIK_MAX)) l = 64'(LIK_MAX);
    if (l < 1) l = 1;
    return l;
  endfunction

  function automatic logic [23:0] posterior_q24(logic [63:0] n, logic [63:0] den);
    logic [127:0] q;
    q = ({64'd0, n} << 25) / {64'd0, den};
    q = (q + 1) >> 1;
    if (q < 128'(PROB_LOW)) return PROB_LOW;
    if (q > 128'(PROB_HIGH)) return PROB_HIGH;
    return 24'(q);
  endfunction

  // bayes update of one leg, returns the expected beat
  function automatic phase_result_t update_leg(logic [1:0] leg, logic [15:0] force_v);
    phase_result_t r;
    logic [63:0] prod [HYP_N];
    logic [63:0] den;
    logic [23:0] post [HYP_N];
    den = 0;
    for (int h = 0; h < HYP_N; h++) begin
      prod[h] = (gauss_q40(force_v, model_mean[h], model_spread[h])
                 * 64'(model_belief[h][leg])) >> 3;
      den = den + prod[h];
    end
    r.kept = (den <= 64'(KEEP_LIMIT));
    for (int h = 0; h < HYP_N; h++) begin
      post[h] = r.kept ? model_belief[h][leg] : posterior_q24(prod[h], den);
      model_belief[h][leg] = post[h];
    end
    r.leg = leg;
    r.p_two = post[0];
    r.p_four = post[1];
    r.p_swing = post[2];
    r.stance = (post[0] > post[2]) || (post[1] > post[2]);
    return r;
  endfunction

  // result beat checker
  always @(posedge clk) begin
    phase_result_t got, want;
    if (rst_n && out_valid && !out_stall) begin
      got = '{out_leg_out, out_stance_flag, out_prob_two_leg_stance,
              out_prob_four_leg_stance, out_prob_swing, out_kept_prior};
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected beat %p", $time, got);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (got.leg !== want.leg) begin
          $display("%0t: leg exp %0d got %0d", $time, want.leg, got.leg);
          error_count++;
        end
        if (got.stance !== want.stance) begin
          $display("%0t: stance exp %0d got %0d", $time, want.stance, got.stance);
          error_count++;
        end
        if (got.p_two !== want.p_two) begin
          $display("%0t: two-leg prob exp %0d got %0d", $time, want.p_two, got.p_two);
          error_count++;
        end
        if (got.p_four !== want.p_four) begin
          $display("%0t: four-leg prob exp %0d got %0d", $time, want.p_four, got.p_four);
          error_count++;
        end
        if (got.p_swing !== want.p_swing) begin
          $display("%0t: swing prob exp %0d got %0d", $time, want.p_swing, got.p_swing);
          error_count++;
        end
        if (got.kept !== want.kept) begin
          $display("%0t: kept prior exp %0d got %0d", $time, want.kept, got.kept);
          error_count++;
        end
      end
    end
  end

  // receiver stalls in short bursts
  always @(posedge clk) begin
    if (quiet || !rst_n) begin
      out_stall <= 1'b0;
      out_gap = 0;
    end else if (out_gap > 0) begin
      out_stall <= 1'b1;
      out_gap--;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall <= 1'b1;
      out_gap = $urandom_range(0, 2);
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic send_force(logic [1:0] leg, logic [15:0] force_v);
    in_leg_number <= leg;
    in_contact_force <= force_v;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(update_leg(leg, force_v));
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // setup and access phase; the caller ends the transfer after the last write
  task automatic write_reg(logic [2:0] idx, logic [15:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {16'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (idx <= REG_MEAN_SWING) model_mean[idx] = value;
    else model_spread[idx - REG_SPREAD_TWO] = value;
  endtask

  task automatic set_hypotheses(logic [15:0] m2, logic [15:0] m4, logic [15:0] ms,
                                logic [15:0] s2, logic [15:0] s4, logic [15:0] ss);
    drain();
    write_reg(REG_MEAN_TWO, m2);
    write_reg(REG_MEAN_FOUR, m4);
    write_reg(REG_MEAN_SWING, ms);
    write_reg(REG_SPREAD_TWO, s2);
    write_reg(REG_SPREAD_FOUR, s4);
    write_reg(REG_SPREAD_SWING, ss);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  // mostly forces near one of the means, some anywhere
  function automatic logic [15:0] pick_force();
    int h;
    int v;
    if ($urandom_range(0, 9) == 0) return 16'($urandom);
    h = $urandom_range(0, HYP_N - 1);
    v = int'(model_mean[h]) + $urandom_range(0, 6 * int'(model_spread[h]) + 1)
        - 3 * int'(model_spread[h]);
    if (v < 0) v = 0;
    if (v > 65535) v = 65535;
    return 16'(v);
  endfunction

  task automatic test_force_extremes;
    for (int leg = 0; leg < 4; leg++) send_force(2'(leg), 16'd0);
    send_force(2'd0, 16'hFFFF);
    send_force(2'd1, model_mean[0]);
    send_force(2'd2, model_mean[1]);
    send_force(2'd3, model_mean[2]);
    send_force(2'd1, 16'h5555);
    send_force(2'd2, 16'hAAAA);
  endtask

  task automatic test_saturated_likelihood;
    set_hypotheses(16'd1000, 16'd2000, 16'd3000, 16'd0, 16'd1, 16'd64);
    send_force(2'd0, 16'd1000);
    send_force(2'd0, 16'd2000);
    send_force(2'd1, 16'd3000);
    send_force(2'd1, 16'd1001);
  endtask

  task automatic test_kept_prior;
    set_hypotheses(16'd0, 16'd0, 16'd0, 16'd64, 16'd64, 16'd64);
    send_force(2'd2, 16'hFFFF);
    send_force(2'd3, 16'd40000);
    set_hypotheses(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_force(2'd2, 16'd0);
    send_force(2'd3, 16'hFFFF);
  endtask

  task automatic test_config_sweep;
    for (int phase = 0; phase < 8; phase++) begin
      set_hypotheses(16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom_range(64, 8000)), 16'($urandom_range(64, 8000)),
                     16'($urandom_range(0, 65535)));
      repeat (60) send_force(2'($urandom), pick_force());
    end
  endtask

  task automatic test_random_gait;
    set_hypotheses(MEAN_RESET[0], MEAN_RESET[1], MEAN_RESET[2],
                   SPREAD_RESET[0], SPREAD_RESET[1], SPREAD_RESET[2]);
    for (int i = 0; i < 1040; i++) begin
      if (i == 840) quiet = 1'b1;
      send_force(2'($urandom), pick_force());
    end
  endtask

  initial begin
    for (int h = 0; h < HYP_N; h++) begin
      model_mean[h] = MEAN_RESET[h];
      model_spread[h] = SPREAD_RESET[h];
      for (int leg = 0; leg < 4; leg++) model_belief[h][leg] = BELIEF_RESET[h];
    end
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_force_extremes();
    test_saturated_likelihood();
    test_kept_prior();
    test_config_sweep();
    test_random_gait();
    drain();
    repeat (1500) @(posedge clk);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
